[design/dss_pkg.sv]
// Shared constants, types and codes for the dense key set with swap removal.
`default_nettype none

package dss_pkg;

  // Store sizing.
  localparam int CAPACITY = 32;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Port widths fixed by the interface.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;
  localparam int COUNT_W  = 6;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // Operation codes; the unused code is handled as a find.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_FOUND     = 3'd5,
    ST_NOT_FOUND = 3'd6
  } status_t;

endpackage

`default_nettype wire

[design/dense_set_swap_remove.sv]
// Dense unordered key set with linear search and swap-with-last removal.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | in_operation, in_key
//   out     | output    | out_valid/out_stall| out_status, out_slot, out_count
//
// A transaction scans the held keys from slot 0, comparing one stored key per
// cycle and stopping at a match, then executes, with a move step for an erase
// that moves the last entry; the next is taken in the cycle after a result loads.
// After reset the set is empty; no clearing pass is needed.
// A new transaction is taken while a finished result waits in the output
// register; a stalled result blocks the next result from loading and then new input.
`default_nettype none

module dense_set_swap_remove (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dss_pkg::OP_W-1:0]      in_operation,
  input  wire logic [dss_pkg::KEY_W-1:0]     in_key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [dss_pkg::STATUS_W-1:0]  out_status,
  output logic      [dss_pkg::SLOT_W-1:0]    out_slot,
  output logic      [dss_pkg::COUNT_W-1:0]   out_count
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_MOVE = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  dss_pkg::op_t      op_r, op_nxt;
  dss_pkg::key_t     key_r, key_nxt;
  dss_pkg::cnt_t     rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  dss_pkg::idx_t     cmp_idx_r, cmp_idx_nxt;
  logic              hit_r, hit_nxt;
  dss_pkg::idx_t     pos_r, pos_nxt;
  dss_pkg::cnt_t     occ_r, occ_nxt;
  dss_pkg::status_t  res_status_r, res_status_nxt;
  dss_pkg::idx_t     res_slot_r, res_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  dss_pkg::status_t  out_status_r, out_status_nxt;
  dss_pkg::idx_t     out_slot_r, out_slot_nxt;
  dss_pkg::cnt_t     out_count_r, out_count_nxt;

  logic              wr_en;
  dss_pkg::idx_t     wr_addr;
  dss_pkg::key_t     wr_data;
  dss_pkg::idx_t     rd_addr;
  dss_pkg::key_t     rd_data;
  dss_pkg::cnt_t     last_cnt;
  logic              key_match;
  logic              out_free;

  // Key store.
  dss_ram #(
    .WIDTH (dss_pkg::KEY_BITS),
    .DEPTH (dss_pkg::CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared comparator and the index of the last held entry.
  assign key_match = cmp_vld_r && (rd_data == key_r);
  assign last_cnt  = occ_r - dss_pkg::cnt_t'(1);
  assign out_free  = !out_valid_r || !out_stall;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    hit_nxt        = hit_r;
    pos_nxt        = pos_r;
    occ_nxt        = occ_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    wr_en          = 1'b0;
    wr_addr        = occ_r[dss_pkg::IDX_W-1:0];
    wr_data        = key_r;
    rd_addr        = rd_idx_r[dss_pkg::IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = dss_pkg::op_t'(in_operation);
          key_nxt    = dss_pkg::key_t'(in_key);
          rd_idx_nxt = '0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        // One read issued and one compare done per cycle.
        if (key_match) begin
          hit_nxt   = 1'b1;
          pos_nxt   = cmp_idx_r;
          state_nxt = S_EXEC;
        end else if (rd_idx_r < occ_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[dss_pkg::IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + dss_pkg::cnt_t'(1);
        end else begin
          hit_nxt   = 1'b0;
          pos_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt    = S_RESP;
        res_slot_nxt = hit_r ? pos_r : '0;
        rd_addr      = last_cnt[dss_pkg::IDX_W-1:0];
        unique case (op_r)
          dss_pkg::OP_INSERT: begin
            if (hit_r) begin
              res_status_nxt = dss_pkg::ST_PRESENT;
            end else if (occ_r == dss_pkg::cnt_t'(dss_pkg::CAPACITY)) begin
              res_status_nxt = dss_pkg::ST_FULL;
            end else begin
              wr_en          = 1'b1;
              res_status_nxt = dss_pkg::ST_INSERTED;
              res_slot_nxt   = occ_r[dss_pkg::IDX_W-1:0];
              occ_nxt        = occ_r + dss_pkg::cnt_t'(1);
            end
          end
          dss_pkg::OP_ERASE: begin
            if (!hit_r) begin
              res_status_nxt = dss_pkg::ST_ABSENT;
            end else begin
              res_status_nxt = dss_pkg::ST_REMOVED;
              if (pos_r != last_cnt[dss_pkg::IDX_W-1:0]) begin
                // The last entry is read now and written to the hole next.
                state_nxt = S_MOVE;
              end else begin
                occ_nxt = last_cnt;
              end
            end
          end
          default: begin
            res_status_nxt = hit_r ? dss_pkg::ST_FOUND : dss_pkg::ST_NOT_FOUND;
          end
        endcase
      end
      S_MOVE: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = rd_data;
        occ_nxt   = last_cnt;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_count_nxt  = out_count_r;
    if ((state_r == S_RESP) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_slot_nxt   = res_slot_r;
      out_count_nxt  = occ_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = dss_pkg::SLOT_W'(out_slot_r);
  assign out_count  = dss_pkg::COUNT_W'(out_count_r);

`ifndef SYNTHESIS
  // The set never holds more keys than the store has entries.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= dss_pkg::cnt_t'(dss_pkg::CAPACITY))
    else $error("occupancy exceeds capacity");

  // The search index never runs past the held entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= occ_r))
    else $error("scan index past occupancy");

  // A move only happens for an erase that hit.
  a_move_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> (hit_r && (op_r == dss_pkg::OP_ERASE)))
    else $error("entry move without an erase hit");

  // A result loads only from the response step.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result loaded outside the response step");
`endif

endmodule

`default_nettype wire

[design/dss_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]                wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic      [WIDTH-1:0]                rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the dense key set with swap removal.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dss_pkg::*;

  // The one operation code that the package leaves unnamed; it acts as a find.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam int POOL_SIZE    = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MIX_ITEMS    = 480;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count;
  } set_result_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = '0;
  logic [KEY_W-1:0]    in_key       = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [COUNT_W-1:0]  out_count;

  // Shadow copy of the set, updated as each transaction is accepted.
  key_t set_keys [CAPACITY];
  int   set_size = 0;

  set_result_t pending_results [$];
  key_t        key_pool [POOL_SIZE];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int error_count    = 0;
  int sent_count     = 0;
  int checked_count  = 0;
  int full_rejects   = 0;
  int swap_removals  = 0;

  dense_set_swap_remove uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_slot     (out_slot),
    .out_count    (out_count)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Applies one operation to the shadow set and returns the result it should produce.
  function automatic set_result_t apply_set_op(logic [OP_W-1:0] op, key_t key);
    set_result_t r;
    int          pos;
    bit          hit;
    pos = 0;
    hit = 1'b0;
    for (int i = 0; i < set_size; i++) begin
      if (!hit && set_keys[i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    r.slot = '0;
    case (op)
      OP_INSERT: begin
        if (hit) begin
          r.status = ST_PRESENT;
          r.slot   = pos[SLOT_W-1:0];
        end else if (set_size >= CAPACITY) begin
          r.status = ST_FULL;
          full_rejects++;
        end else begin
          set_keys[set_size] = key;
          r.slot   = set_size[SLOT_W-1:0];
          r.status = ST_INSERTED;
          set_size++;
        end
      end
      OP_ERASE: begin
        if (hit) begin
          // The last entry fills the hole unless it is the one removed.
          if (pos != set_size - 1) begin
            set_keys[pos] = set_keys[set_size-1];
            swap_removals++;
          end
          set_size--;
          r.status = ST_REMOVED;
          r.slot   = pos[SLOT_W-1:0];
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        r.status = hit ? ST_FOUND : ST_NOT_FOUND;
        if (hit) r.slot = pos[SLOT_W-1:0];
      end
    endcase
    r.count = set_size[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Compares one accepted result with the oldest expectation.
  task automatic check_result();
    set_result_t want;
    checked_count++;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result status %0d slot %0d count %0d",
                                out_status, out_slot, out_count));
    end else begin
      want = pending_results.pop_front();
      if (out_status !== want.status)
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  checked_count, out_status, want.status));
      if (out_slot !== want.slot)
        report_mismatch($sformatf("result %0d slot %0d, want %0d",
                                  checked_count, out_slot, want.slot));
      if (out_count !== want.count)
        report_mismatch($sformatf("result %0d count %0d, want %0d",
                                  checked_count, out_count, want.count));
    end
  endtask

  // Result side: checks each transaction, then picks the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offers one transaction after a random gap and waits until it is taken.
  task automatic send_item(input logic [OP_W-1:0] op, input key_t key);
    int          gap;
    set_result_t want;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= KEY_W'(key);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = apply_set_op(op, key);
    pending_results = {pending_results, want};
    sent_count++;
  endtask

  // Drops the input valid and waits until every expected result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic refill_key_pool();
    foreach (key_pool[i]) key_pool[i] = key_t'($urandom);
  endtask

  // Mostly keys that may be held, so that hits are common.
  function automatic key_t pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 30 && set_size > 0) return set_keys[$urandom_range(set_size - 1)];
    if (r < 80) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return key_t'($urandom);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 45) return OP_INSERT;
    if (r < 75) return OP_ERASE;
    if (r < 96) return OP_FIND;
    return OP_SPARE;
  endfunction

  // Empty-set cases, key extremes, duplicates, swap and last-entry removal.
  task automatic test_directed();
    send_item(OP_FIND,   32'h0000_0000);
    send_item(OP_ERASE,  32'h0000_0000);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'h8000_0001);
    send_item(OP_INSERT, 32'h7FFF_FFFE);
    send_item(OP_FIND,   32'hFFFF_FFFF);
    send_item(OP_SPARE,  32'h8000_0001);
    send_item(OP_SPARE,  32'h0000_1234);
    send_item(OP_ERASE,  32'h0000_0000);
    send_item(OP_FIND,   32'h7FFF_FFFE);
    send_item(OP_ERASE,  32'h8000_0001);
    send_item(OP_ERASE,  32'hFFFF_FFFF);
    send_item(OP_ERASE,  32'h7FFF_FFFE);
    send_item(OP_ERASE,  32'hFFFF_FFFF);
    send_item(OP_FIND,   32'hFFFF_FFFF);
    wait_for_results();
  endtask

  // Random operations over a small key pool.
  task automatic test_random_mix(input int n);
    for (int i = 0; i < n; i++) send_item(pick_op(), pick_key());
  endtask

  // Fills the store, knocks on it while full, then empties it in random order.
  task automatic test_fill_and_drain();
    while (set_size < CAPACITY) send_item(OP_INSERT, pick_key());
    repeat (3) send_item(OP_INSERT, key_t'($urandom));
    repeat (2) send_item(OP_INSERT, set_keys[$urandom_range(CAPACITY - 1)]);
    send_item(OP_FIND, set_keys[CAPACITY-1]);
    while (set_size > 0) begin
      if ($urandom_range(9) == 0) send_item(OP_ERASE, key_t'($urandom));
      else send_item(OP_ERASE, set_keys[$urandom_range(set_size - 1)]);
    end
  endtask

  // Long result stall while inputs keep coming, so the block backs up.
  task automatic test_backpressure();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (12) send_item(pick_op(), pick_key());
    send_idle_pct = saved_pct;
    wait_for_results();
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct);
    set_idling(send_pct, recv_pct);
    refill_key_pool();
    test_random_mix(MIX_ITEMS / 2);
    test_fill_and_drain();
    test_backpressure();
    test_random_mix(MIX_ITEMS / 2);
    test_fill_and_drain();
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_idling(37, 75);
    test_directed();
    run_phase(37, 75);
    run_phase(75, 37);
    run_phase(0, 0);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d transactions sent and %0d results checked in %0d cycles",
             sent_count, checked_count, cycle_count);
    $display("%0d inserts rejected on a full store, %0d removals moved the last entry",
             full_rejects, swap_removals);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
